// File: rtl/core/kplc_pkg.sv
// shared types and constants for the keypad pin lock controller
`timescale 1ns / 1ps

package kplc_pkg;

   localparam logic [7:0] KEY_NONE   = 8'h00;
   localparam logic [7:0] KEY_DELETE = 8'h2A;
   localparam logic [7:0] KEY_SUBMIT = 8'h23;
   localparam logic [7:0] KEY_CHANGE = 8'h2F;

   localparam logic [7:0] PIN_BASE = 8'h31;

   localparam logic [7:0] CSR_LOGIN_LIMIT  = 8'd0;
   localparam logic [7:0] CSR_UPDATE_LIMIT = 8'd1;

   localparam logic [1:0] LIMIT_RESET = 2'd3;

   typedef enum logic [2:0] {
      OP_NONE   = 3'd0,
      OP_DIGIT  = 3'd1,
      OP_DELETE = 3'd2,
      OP_SUBMIT = 3'd3,
      OP_CHANGE = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      MODE_HOME    = 2'd0,
      MODE_VERIFY  = 2'd1,
      MODE_NEW     = 2'd2,
      MODE_CONFIRM = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_NONE      = 4'd0,
      ST_CORRECT   = 4'd1,
      ST_WRONG     = 4'd2,
      ST_LOCKOUT   = 4'd3,
      ST_VERIFIED  = 4'd4,
      ST_NEW_TAKEN = 4'd5,
      ST_WEAK      = 4'd6,
      ST_DIFFERENT = 4'd7,
      ST_UPDATED   = 4'd8,
      ST_UPD_FAIL  = 4'd9
   } status_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  key;
   } cmd_type;

endpackage

// File: rtl/core/kplc_if.sv
// channel interfaces for key input, result output and register writes
`timescale 1ns / 1ps

interface kplc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] key;

   modport source (output valid, output key, input ready);
   modport sink (input valid, input key, output ready);
endinterface

interface kplc_rsp_if #(parameter int CNT_W = 3);
   logic             valid;
   logic             ready;
   logic [3:0]       status;
   logic [1:0]       mode;
   logic [CNT_W-1:0] digits_entered;
   logic [1:0]       failed_logins;

   modport source (output valid, output status, output mode, output digits_entered,
                   output failed_logins, input ready);
   modport sink (input valid, input status, input mode, input digits_entered,
                 input failed_logins, output ready);
endinterface

interface kplc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/kplc_front.sv
// key intake: classifies each key code into a command
`timescale 1ns / 1ps

module kplc_front import kplc_pkg::*; (
   kplc_req_if.sink  req_ch,
   output logic      push_valid,
   output cmd_type   push_cmd,
   input  logic      push_ready
);

   op_type op;

   always_comb begin
      case (req_ch.key)
         KEY_NONE:   op = OP_NONE;
         KEY_DELETE: op = OP_DELETE;
         KEY_SUBMIT: op = OP_SUBMIT;
         KEY_CHANGE: op = OP_CHANGE;
         default:    op = OP_DIGIT;
      endcase
   end

   assign push_valid   = req_ch.valid;
   assign push_cmd.op  = op;
   assign push_cmd.key = req_ch.key;
   assign req_ch.ready = push_ready;

endmodule

// File: rtl/core/kplc_queue.sv
// two-entry command queue between intake and execution
`timescale 1ns / 1ps

module kplc_queue import kplc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop_ready
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/kplc_back.sv
// command execution: entry buffers, pin compare, failure counters, result register
`timescale 1ns / 1ps

module kplc_back import kplc_pkg::*; #(
   parameter int PIN_DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_ready,
   kplc_csr_if.sink    csr_ch,
   kplc_rsp_if.source  rsp_ch
);

   localparam int CNT_W = $clog2(PIN_DIGITS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PIN_DIGITS);

   typedef logic [7:0] pin_type [PIN_DIGITS];

   mode_type         mode_ff, mode_in;
   pin_type          entry_ff, entry_in;
   pin_type          new_ff, new_in;
   pin_type          confirm_ff, confirm_in;
   pin_type          stored_ff, stored_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       login_fail_ff, login_fail_in;
   logic [1:0]       update_fail_ff, update_fail_in;
   logic [1:0]       login_limit_ff, update_limit_ff;
   status_type       status_ff, status_in;
   logic             rsp_valid_ff;

   pin_type    act, shift_dig, shift_del;
   logic       entry_match, new_weak, new_same;
   logic [1:0] login_next, update_next, login_lim, update_lim;
   logic       pop;

   assign cmd_ready = !rsp_valid_ff || rsp_ch.ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      case (mode_ff)
         MODE_NEW:     act = new_ff;
         MODE_CONFIRM: act = confirm_ff;
         default:      act = entry_ff;
      endcase
      for (int i = 0; i < PIN_DIGITS - 1; i++) begin
         shift_dig[i] = act[i + 1];
      end
      shift_dig[PIN_DIGITS - 1] = cmd.key;
      shift_del[0] = 8'h00;
      for (int i = 1; i < PIN_DIGITS; i++) begin
         shift_del[i] = act[i - 1];
      end
      entry_match = 1'b1;
      new_weak    = 1'b0;
      new_same    = 1'b1;
      for (int i = 0; i < PIN_DIGITS; i++) begin
         if (entry_ff[i] != stored_ff[i]) entry_match = 1'b0;
         if (new_ff[i] == 8'h00) new_weak = 1'b1;
         if (new_ff[i] != confirm_ff[i]) new_same = 1'b0;
      end
   end

   assign login_next  = login_fail_ff + 2'd1;
   assign update_next = update_fail_ff + 2'd1;
   assign login_lim   = (login_limit_ff == 2'd0) ? 2'd1 : login_limit_ff;
   assign update_lim  = (update_limit_ff == 2'd0) ? 2'd1 : update_limit_ff;

   always_comb begin
      mode_in        = mode_ff;
      entry_in       = entry_ff;
      new_in         = new_ff;
      confirm_in     = confirm_ff;
      stored_in      = stored_ff;
      count_in       = count_ff;
      login_fail_in  = login_fail_ff;
      update_fail_in = update_fail_ff;
      status_in      = ST_NONE;
      case (cmd.op)
         OP_DIGIT: begin
            case (mode_ff)
               MODE_NEW:     new_in = shift_dig;
               MODE_CONFIRM: confirm_in = shift_dig;
               default:      entry_in = shift_dig;
            endcase
            if (count_ff < CNT_FULL) count_in = count_ff + CNT_W'(1);
         end
         OP_DELETE: begin
            if (count_ff != '0) begin
               case (mode_ff)
                  MODE_NEW:     new_in = shift_del;
                  MODE_CONFIRM: confirm_in = shift_del;
                  default:      entry_in = shift_del;
               endcase
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_SUBMIT: begin
            case (mode_ff)
               MODE_NEW: begin
                  count_in  = '0;
                  mode_in   = MODE_CONFIRM;
                  status_in = ST_NEW_TAKEN;
               end
               MODE_CONFIRM: begin
                  new_in     = '{default: 8'h00};
                  confirm_in = '{default: 8'h00};
                  count_in   = '0;
                  if (!new_weak && new_same) begin
                     stored_in      = confirm_ff;
                     update_fail_in = 2'd0;
                     mode_in        = MODE_HOME;
                     status_in      = ST_UPDATED;
                  end else if (update_next >= update_lim) begin
                     update_fail_in = 2'd0;
                     mode_in        = MODE_HOME;
                     status_in      = ST_UPD_FAIL;
                  end else begin
                     update_fail_in = update_next;
                     mode_in        = MODE_NEW;
                     status_in      = new_weak ? ST_WEAK : ST_DIFFERENT;
                  end
               end
               default: begin
                  entry_in = '{default: 8'h00};
                  count_in = '0;
                  if (entry_match) begin
                     login_fail_in = 2'd0;
                     if (mode_ff == MODE_VERIFY) begin
                        mode_in   = MODE_NEW;
                        status_in = ST_VERIFIED;
                     end else begin
                        status_in = ST_CORRECT;
                     end
                  end else if (login_next >= login_lim) begin
                     login_fail_in = 2'd0;
                     mode_in       = MODE_HOME;
                     status_in     = ST_LOCKOUT;
                  end else begin
                     login_fail_in = login_next;
                     status_in     = ST_WRONG;
                  end
               end
            endcase
         end
         OP_CHANGE: begin
            if (mode_ff == MODE_HOME) begin
               entry_in = '{default: 8'h00};
               count_in = '0;
               mode_in  = MODE_VERIFY;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_HOME;
         entry_ff       <= '{default: 8'h00};
         new_ff         <= '{default: 8'h00};
         confirm_ff     <= '{default: 8'h00};
         for (int i = 0; i < PIN_DIGITS; i++) begin
            stored_ff[i] <= PIN_BASE + 8'(i);
         end
         count_ff       <= '0;
         login_fail_ff  <= 2'd0;
         update_fail_ff <= 2'd0;
         rsp_valid_ff   <= 1'b0;
         status_ff      <= ST_NONE;
      end else begin
         if (pop) begin
            mode_ff        <= mode_in;
            entry_ff       <= entry_in;
            new_ff         <= new_in;
            confirm_ff     <= confirm_in;
            stored_ff      <= stored_in;
            count_ff       <= count_in;
            login_fail_ff  <= login_fail_in;
            update_fail_ff <= update_fail_in;
            status_ff      <= status_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   // limit registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         login_limit_ff  <= LIMIT_RESET;
         update_limit_ff <= LIMIT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_LOGIN_LIMIT:  login_limit_ff <= csr_ch.data[1:0];
            CSR_UPDATE_LIMIT: update_limit_ff <= csr_ch.data[1:0];
            default: begin
            end
         endcase
      end
   end

   // state registers only move on a transfer, so they equal the held result
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.mode           = mode_ff;
   assign rsp_ch.digits_entered = count_ff;
   assign rsp_ch.failed_logins  = login_fail_ff;

endmodule

// File: rtl/core/keypad_pin_lock_controller_unit.sv
// top level of the keypad pin lock controller
//
//  channel  dir  handshake              payload
//  req_ch   in   valid/ready            key
//  rsp_ch   out  valid/ready            status, mode, digits_entered, failed_logins
//  csr_ch   in   valid/ready (ready=1)  index, data
//
// one key per cycle sustained while rsp_ch is ready; after its transfer a key is
// classified into the two-entry queue, then executed into the result register.
// synchronous active-high reset restores the default pin and limits of three.
// a stalled result holds the executor; the queue absorbs keys until it is full.
`timescale 1ns / 1ps

module keypad_pin_lock_controller_unit import kplc_pkg::*; #(
   parameter int PIN_DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   kplc_req_if.sink    req_ch,
   kplc_rsp_if.source  rsp_ch,
   kplc_csr_if.sink    csr_ch
);

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   kplc_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   kplc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   kplc_back #(
      .PIN_DIGITS (PIN_DIGITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_ready (pop_ready),
      .csr_ch    (csr_ch),
      .rsp_ch    (rsp_ch)
   );

endmodule

// File: tb/keypad_pin_lock_controller_unit_tb.sv
// self-checking testbench for the keypad pin lock controller unit
`timescale 1ns / 1ps

module keypad_pin_lock_controller_unit_tb import kplc_pkg::*; ();

   localparam int NUM_PHASES = 8;
   localparam int KEYS_PER_PHASE = 200;
   localparam int IDLE_LIMIT = 1000;

   typedef struct packed {
      status_type  status;
      mode_type    mode;
      logic [2:0]  digits;
      logic [1:0]  fails;
   } lock_reply_type;

   typedef struct packed {
      logic            typed;
      lock_reply_type  reply;
   } key_note_type;

   typedef struct packed {
      logic [7:0]      key;
      logic            typed;
      lock_reply_type  reply;
   } directed_row_type;

   logic clock;
   logic reset;

   kplc_req_if                req_ch ();
   kplc_rsp_if #(.CNT_W(3))   rsp_ch ();
   kplc_csr_if                csr_ch ();

   keypad_pin_lock_controller_unit #(.PIN_DIGITS(4)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // lock state as the block should hold it
   logic [3:0][7:0] pin_now   = {8'h34, 8'h33, 8'h32, 8'h31};
   logic [3:0][7:0] entry_now = '0;
   logic [3:0][7:0] new_now   = '0;
   logic [3:0][7:0] conf_now  = '0;
   mode_type        mode_now  = MODE_HOME;
   logic [2:0]      count_now = '0;
   logic [1:0]      fails_now = '0;
   logic [1:0]      upd_now   = '0;
   logic [1:0]      login_lim = LIMIT_RESET;
   logic [1:0]      update_lim = LIMIT_RESET;

   lock_reply_type expected_replies [$];
   key_note_type   pending_notes [$];
   int             mismatches = 0;
   int             idle_cycles = 0;
   int             burst_left = 0;
   int             keys_sent = 0;
   lock_reply_type want;
   key_note_type   note_now;
   lock_reply_type got_now;

   logic [1:0] login_plan  [NUM_PHASES] = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd1, 2'd3, 2'd2, 2'd3};
   logic [1:0] update_plan [NUM_PHASES] = '{2'd3, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0};

   directed_row_type dir_rows [24] = '{
      '{KEY_NONE,   1'b1, '{ST_NONE,      MODE_HOME,    3'd0, 2'd0}},
      '{KEY_DELETE, 1'b1, '{ST_NONE,      MODE_HOME,    3'd0, 2'd0}},
      '{KEY_SUBMIT, 1'b1, '{ST_WRONG,     MODE_HOME,    3'd0, 2'd1}},
      '{8'h31,      1'b0, '0},
      '{8'h32,      1'b0, '0},
      '{8'h33,      1'b0, '0},
      '{8'h34,      1'b0, '0},
      '{KEY_SUBMIT, 1'b1, '{ST_CORRECT,   MODE_HOME,    3'd0, 2'd0}},
      '{KEY_CHANGE, 1'b1, '{ST_NONE,      MODE_VERIFY,  3'd0, 2'd0}},
      '{KEY_CHANGE, 1'b1, '{ST_NONE,      MODE_VERIFY,  3'd0, 2'd0}},
      '{8'hFF,      1'b0, '0},
      '{KEY_SUBMIT, 1'b1, '{ST_WRONG,     MODE_VERIFY,  3'd0, 2'd1}},
      '{KEY_SUBMIT, 1'b1, '{ST_WRONG,     MODE_VERIFY,  3'd0, 2'd2}},
      '{KEY_SUBMIT, 1'b1, '{ST_LOCKOUT,   MODE_HOME,    3'd0, 2'd0}},
      '{KEY_CHANGE, 1'b0, '0},
      '{8'h31,      1'b0, '0},
      '{8'h32,      1'b0, '0},
      '{8'h33,      1'b0, '0},
      '{8'h34,      1'b0, '0},
      '{KEY_SUBMIT, 1'b1, '{ST_VERIFIED,  MODE_NEW,     3'd0, 2'd0}},
      '{8'h01,      1'b0, '0},
      '{8'h80,      1'b0, '0},
      '{KEY_SUBMIT, 1'b1, '{ST_NEW_TAKEN, MODE_CONFIRM, 3'd0, 2'd0}},
      '{KEY_SUBMIT, 1'b1, '{ST_WEAK,      MODE_NEW,     3'd0, 2'd0}}
   };

   function automatic logic [1:0] active_limit(input logic [1:0] lim);
      return (lim == 2'd0) ? 2'd1 : lim;
   endfunction

   function automatic lock_reply_type advance_lock(input logic [7:0] key);
      logic [3:0][7:0] shift_v;
      logic            edited;
      logic            has_zero;
      status_type      st;
      lock_reply_type  r;
      st = ST_NONE;
      edited = 1'b0;
      case (mode_now)
         MODE_NEW:     shift_v = new_now;
         MODE_CONFIRM: shift_v = conf_now;
         default:      shift_v = entry_now;
      endcase
      if (key == KEY_NONE) begin
         edited = 1'b0;
      end else if (key != KEY_DELETE && key != KEY_SUBMIT && key != KEY_CHANGE) begin
         shift_v = {key, shift_v[3:1]};
         if (count_now < 3'd4) count_now = count_now + 3'd1;
         edited = 1'b1;
      end else if (key == KEY_DELETE) begin
         if (count_now != 3'd0) begin
            shift_v = {shift_v[2:0], 8'h00};
            count_now = count_now - 3'd1;
            edited = 1'b1;
         end
      end else if (key == KEY_SUBMIT) begin
         if (mode_now == MODE_NEW) begin
            count_now = '0;
            mode_now = MODE_CONFIRM;
            st = ST_NEW_TAKEN;
         end else if (mode_now == MODE_CONFIRM) begin
            has_zero = 1'b0;
            for (int i = 0; i < 4; i++)
               if (new_now[i] == 8'h00) has_zero = 1'b1;
            if (!has_zero && new_now == conf_now) begin
               pin_now = conf_now;
               upd_now = '0;
               mode_now = MODE_HOME;
               st = ST_UPDATED;
            end else begin
               st = has_zero ? ST_WEAK : ST_DIFFERENT;
               mode_now = MODE_NEW;
               upd_now = upd_now + 2'd1;
               if (upd_now >= active_limit(update_lim)) begin
                  upd_now = '0;
                  mode_now = MODE_HOME;
                  st = ST_UPD_FAIL;
               end
            end
            new_now = '0;
            conf_now = '0;
            count_now = '0;
         end else begin
            if (entry_now == pin_now) begin
               fails_now = '0;
               if (mode_now == MODE_VERIFY) begin
                  mode_now = MODE_NEW;
                  st = ST_VERIFIED;
               end else begin
                  st = ST_CORRECT;
               end
            end else begin
               fails_now = fails_now + 2'd1;
               if (fails_now >= active_limit(login_lim)) begin
                  fails_now = '0;
                  mode_now = MODE_HOME;
                  st = ST_LOCKOUT;
               end else begin
                  st = ST_WRONG;
               end
            end
            entry_now = '0;
            count_now = '0;
         end
      end else if (mode_now == MODE_HOME) begin
         entry_now = '0;
         count_now = '0;
         mode_now = MODE_VERIFY;
      end
      if (edited) begin
         case (mode_now)
            MODE_NEW:     new_now = shift_v;
            MODE_CONFIRM: conf_now = shift_v;
            default:      entry_now = shift_v;
         endcase
      end
      r.status = st;
      r.mode = mode_now;
      r.digits = count_now;
      r.fails = fails_now;
      return r;
   endfunction

   function automatic logic [7:0] pick_digit();
      logic [7:0] d;
      d = 8'($urandom_range(0, 9));
      if ($urandom_range(0, 3) != 0) return 8'h30 + d;
      d = KEY_NONE;
      while (d == KEY_NONE || d == KEY_DELETE || d == KEY_SUBMIT || d == KEY_CHANGE)
         d = 8'($urandom_range(1, 255));
      return d;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int exp_val);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, exp_val);
      mismatches++;
   endtask

   // all stimulus tasks start and end at a falling edge
   task automatic send_key(input logic [7:0] k, input logic typed,
                           input lock_reply_type reply);
      int           gap;
      key_note_type note;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            req_ch.valid <= 1'b0;
            req_ch.key <= 8'($urandom_range(0, 255));
            @(negedge clock);
         end
      end
      note.typed = typed;
      note.reply = reply;
      pending_notes.push_back(note);
      req_ch.valid <= 1'b1;
      req_ch.key <= k;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
      keys_sent++;
      @(negedge clock);
   endtask

   task automatic press(input logic [7:0] k);
      send_key(k, 1'b0, '0);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limits(input logic [1:0] login_val, input logic [1:0] update_val);
      logic [5:0] junk;
      for (int i = 0; i < 2; i++) begin
         junk = 6'($urandom_range(0, 63));
         csr_ch.valid <= 1'b1;
         csr_ch.index <= (i == 0) ? CSR_LOGIN_LIMIT : CSR_UPDATE_LIMIT;
         csr_ch.data <= {junk, (i == 0) ? login_val : update_val};
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
         @(negedge clock);
      end
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_session();
      int              kind;
      int              n;
      int              j;
      logic [3:0][7:0] pin;
      logic [7:0]      fresh [4];
      kind = $urandom_range(0, 9);
      pin = pin_now;
      if (kind < 3) begin
         repeat ($urandom_range(0, 2)) press(pick_digit());
         if ($urandom_range(0, 3) != 0) begin
            for (int i = 0; i < 4; i++) press(pin[i]);
         end else begin
            repeat ($urandom_range(0, 5)) press(pick_digit());
         end
         if ($urandom_range(0, 5) == 0) press(KEY_DELETE);
         press(KEY_SUBMIT);
      end else if (kind < 8) begin
         if (mode_now != MODE_NEW) begin
            press(KEY_CHANGE);
            if ($urandom_range(0, 5) != 0) begin
               for (int i = 0; i < 4; i++) press(pin[i]);
            end else begin
               repeat (4) press(pick_digit());
            end
            press(KEY_SUBMIT);
         end
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 4;
         for (int i = 0; i < 4; i++) fresh[i] = pick_digit();
         for (int i = 0; i < n; i++) press(fresh[i]);
         press(KEY_SUBMIT);
         if ($urandom_range(0, 5) == 0) begin
            j = $urandom_range(0, 3);
            fresh[j] = pick_digit();
         end
         if ($urandom_range(0, 9) == 0) press(KEY_DELETE);
         for (int i = 0; i < n; i++) press(fresh[i]);
         press(KEY_SUBMIT);
      end else begin
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 5))
               0: press(KEY_NONE);
               1: press(KEY_DELETE);
               2: press(KEY_SUBMIT);
               3: press(KEY_CHANGE);
               default: press(8'($urandom_range(0, 255)));
            endcase
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : rsp_stall
      logic [7:0] pattern;
      int         left;
      int         pos;
      left = 0;
      pos = 0;
      pattern = 8'hFF;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            left = $urandom_range(16, 80);
            pattern = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 2) == 0) pattern = 8'hFF;
            pattern[0] = 1'b1;
         end
         rsp_ch.ready <= pattern[pos];
         pos = (pos + 1) % 8;
         left--;
      end
   end

   // checks results, tracks transfers and keeps the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected result, status", int'(rsp_ch.status), -1);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_ch.status != want.status)
                  report_mismatch("status", int'(rsp_ch.status), int'(want.status));
               if (rsp_ch.mode != want.mode)
                  report_mismatch("mode", int'(rsp_ch.mode), int'(want.mode));
               if (rsp_ch.digits_entered != want.digits)
                  report_mismatch("digits_entered", int'(rsp_ch.digits_entered),
                                  int'(want.digits));
               if (rsp_ch.failed_logins != want.fails)
                  report_mismatch("failed_logins", int'(rsp_ch.failed_logins),
                                  int'(want.fails));
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_LOGIN_LIMIT) login_lim = csr_ch.data[1:0];
            else if (csr_ch.index == CSR_UPDATE_LIMIT) update_lim = csr_ch.data[1:0];
         end
         if (req_ch.valid && req_ch.ready) begin
            note_now = pending_notes.pop_front();
            got_now = advance_lock(req_ch.key);
            expected_replies.push_back(note_now.typed ? note_now.reply : got_now);
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (csr_ch.valid && csr_ch.ready) ||
             (req_ch.valid && req_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int target;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.key <= KEY_NONE;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_LOGIN_LIMIT;
      csr_ch.data <= '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_key(dir_rows[i].key, dir_rows[i].typed, dir_rows[i].reply);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         write_limits(login_plan[ph], update_plan[ph]);
         target = keys_sent + KEYS_PER_PHASE;
         while (keys_sent < target) run_session();
      end
      settle();

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
